FILE: rtl/core/rnd_pkg.sv
`default_nettype none
package rnd_pkg;

  localparam int COORD_W         = 16;
  localparam int ROW_W           = 20;
  localparam int COL_W           = 16;
  localparam int ROWNUM_W        = ROW_W + 1;
  localparam int COLNUM_W        = COL_W + 1;
  localparam int RAD_W           = 17;
  localparam int DIFF_W          = COORD_W + 1;
  localparam int MAG_W           = DIFF_W;
  localparam int SQ_W            = 2 * MAG_W;
  localparam int ROOT_W          = SQ_W / 2;
  localparam int REM_W           = ROOT_W + 3;
  localparam int DIR_FRAC        = 14;
  localparam int DIR_W           = 16;
  localparam int QUO_W           = DIR_FRAC + 1;
  localparam int DREM_W          = ROOT_W + 1;
  localparam int STEPS_PER_STAGE = 2;
  localparam int SQRT_STAGES     = (ROOT_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int DIV_STAGES      = (QUO_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  // Digit-by-digit square root state.
  typedef struct packed {
    logic [SQ_W-1:0]   rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_st_t;

  // Fields that travel beside the square root pipeline.
  typedef struct packed {
    logic             hit;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [MAG_W-1:0] mag_x;
    logic [MAG_W-1:0] mag_y;
    logic             neg_x;
    logic             neg_y;
  } side_t;

  // Restoring division state.
  typedef struct packed {
    logic [DREM_W-1:0] rem;
    logic [QUO_W-1:0]  bits;
    logic [QUO_W-1:0]  quo;
    logic [ROOT_W-1:0] dvs;
  } div_st_t;

  function automatic sqrt_st_t sqrt_step(input sqrt_st_t s);
    sqrt_st_t   o;
    logic [REM_W-1:0] r;
    logic [REM_W-1:0] trial;
    r     = {s.rem[REM_W-3:0], s.rad[SQ_W-1 -: 2]};
    trial = {1'b0, s.root, 2'b01};
    o.rad = {s.rad[SQ_W-3:0], 2'b00};
    if (r >= trial) begin
      o.rem  = r - trial;
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = r;
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic div_st_t div_step(input div_st_t s);
    div_st_t           o;
    logic [DREM_W-1:0] r;
    logic [DREM_W-1:0] d;
    r      = {s.rem[DREM_W-2:0], s.bits[QUO_W-1]};
    d      = {1'b0, s.dvs};
    o.dvs  = s.dvs;
    o.bits = {s.bits[QUO_W-2:0], 1'b0};
    if (r >= d) begin
      o.rem = r - d;
      o.quo = {s.quo[QUO_W-2:0], 1'b1};
    end else begin
      o.rem = r;
      o.quo = {s.quo[QUO_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/rnd_isqrt.sv
`default_nettype none
module rnd_isqrt (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic [rnd_pkg::SQ_W-1:0]      in_rad,
  input  wire rnd_pkg::side_t                in_side,
  output logic                               out_valid,
  output logic [rnd_pkg::ROOT_W-1:0]         out_root,
  output rnd_pkg::side_t                     out_side
);
  import rnd_pkg::*;

  sqrt_st_t st_r   [SQRT_STAGES];
  side_t    side_r [SQRT_STAGES];
  logic     vld_r  [SQRT_STAGES];

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stg
    sqrt_st_t cur;
    sqrt_st_t st_nxt;
    side_t    side_in;
    logic     vin;

    if (s == 0) begin : g_first
      assign cur     = '{rad: in_rad, rem: '0, root: '0};
      assign side_in = in_side;
      assign vin     = in_valid;
    end else begin : g_next
      assign cur     = st_r[s-1];
      assign side_in = side_r[s-1];
      assign vin     = vld_r[s-1];
    end

    // Two result bits per stage; the last stage may have only one.
    always_comb begin
      st_nxt = cur;
      for (int k = 0; k < STEPS_PER_STAGE; k++) begin
        if (s * STEPS_PER_STAGE + k < ROOT_W) begin
          st_nxt = sqrt_step(st_nxt);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      st_r[s]   <= st_nxt;
      side_r[s] <= side_in;
    end
  end

  assign out_valid = vld_r[SQRT_STAGES-1];
  assign out_root  = st_r[SQRT_STAGES-1].root;
  assign out_side  = side_r[SQRT_STAGES-1];

endmodule
`default_nettype wire

FILE: rtl/core/rnd_divider.sv
`default_nettype none
module rnd_divider (
  input  wire logic                          clk,
  input  wire logic [rnd_pkg::MAG_W-1:0]     in_mag,
  input  wire logic [rnd_pkg::ROOT_W-1:0]    in_dvs,
  output logic [rnd_pkg::QUO_W-1:0]          out_quo
);
  import rnd_pkg::*;

  // With a nonzero divisor the quotient is at most 2^DIR_FRAC: the divisor
  // is never below the magnitude, so the upper numerator bits start below it.
  div_st_t st_r [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stg
    div_st_t cur;
    div_st_t st_nxt;

    if (s == 0) begin : g_first
      assign cur = '{rem:  {1'b0, in_mag[MAG_W-1:1]},
                     bits: {in_mag[0], {(QUO_W-1){1'b0}}},
                     quo:  '0,
                     dvs:  in_dvs};
    end else begin : g_next
      assign cur = st_r[s-1];
    end

    always_comb begin
      st_nxt = cur;
      for (int k = 0; k < STEPS_PER_STAGE; k++) begin
        if (s * STEPS_PER_STAGE + k < QUO_W) begin
          st_nxt = div_step(st_nxt);
        end
      end
    end

    always_ff @(posedge clk) begin
      st_r[s] <= st_nxt;
    end
  end

  assign out_quo = st_r[DIV_STAGES-1].quo;

endmodule
`default_nettype wire

FILE: rtl/core/radius_neighbor_distance_unit.sv
`default_nettype none
// Fixed-radius neighbor distance unit.
// One item is a query location and a grid location with their indices. The
// unit forms the offset (query minus grid), flags a hit when the squared
// offset is nonzero and below radius squared, and for a hit reports the
// one-based indices, the floor square root distance and the two direction
// components, offset * 2^14 / distance truncated toward zero. A miss
// reports all fields as zero.
// The input channel takes an item on every clock edge where start is high
// and busy is low; busy is always low, so one item can enter every cycle.
// Each result appears for a single cycle with out_valid high, in item
// order, after the offset, magnitude, square and compare stages, the
// square root pipeline (two root bits per stage), the two direction
// dividers (two quotient bits per stage) and the output register.
// The receiver cannot stall, so no buffering is needed on the output side.
// The radius register is written through cfg_valid/cfg_ready (always
// ready) and must only change while no item is in flight. Synchronous
// reset clears the radius to zero and drops every item in flight.
module radius_neighbor_distance_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [rnd_pkg::ROW_W-1:0]       in_row_index,
  input  wire logic [rnd_pkg::COL_W-1:0]       in_col_index,
  input  wire logic signed [rnd_pkg::COORD_W-1:0] in_query_x,
  input  wire logic signed [rnd_pkg::COORD_W-1:0] in_query_y,
  input  wire logic signed [rnd_pkg::COORD_W-1:0] in_grid_x,
  input  wire logic signed [rnd_pkg::COORD_W-1:0] in_grid_y,
  output logic                                 out_valid,
  output logic                                 out_hit,
  output logic [rnd_pkg::ROWNUM_W-1:0]         out_row_number,
  output logic [rnd_pkg::COLNUM_W-1:0]         out_col_number,
  output logic [rnd_pkg::ROOT_W-1:0]           out_distance,
  output logic signed [rnd_pkg::DIR_W-1:0]     out_dir_x,
  output logic signed [rnd_pkg::DIR_W-1:0]     out_dir_y,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [rnd_pkg::RAD_W-1:0]       cfg_radius
);
  import rnd_pkg::*;

  // Payload of the tail that runs beside the dividers.
  typedef struct packed {
    logic              hit;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [ROOT_W-1:0] root;
    logic              neg_x;
    logic              neg_y;
  } tail_t;

  logic [RAD_W-1:0]  radius_r;
  logic [SQ_W-1:0]   r2_r;

  logic              v1_r, v2_r, v3_r, v4_r;
  logic [ROW_W-1:0]  row1_r, row2_r, row3_r, row4_r;
  logic [COL_W-1:0]  col1_r, col2_r, col3_r, col4_r;
  logic signed [DIFF_W-1:0] dx_r, dy_r;
  logic [MAG_W-1:0]  ax2_r, ay2_r, ax3_r, ay3_r, ax4_r, ay4_r;
  logic              nx2_r, ny2_r, nx3_r, ny3_r, nx4_r, ny4_r;
  logic [SQ_W-1:0]   sqx_r, sqy_r, sum_r;
  logic              hit4_r;

  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  side_t             sq_side;
  side_t             side4;

  logic              tv_r   [DIV_STAGES];
  tail_t             tail_r [DIV_STAGES];
  logic [QUO_W-1:0]  quo_x, quo_y;

  logic [DIR_W-1:0]  qx_ext, qy_ext;
  tail_t             tl;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // The radius square is registered from the stored radius on every clock.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= '0;
      r2_r     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        radius_r <= cfg_radius;
      end
      r2_r <= SQ_W'(radius_r) * SQ_W'(radius_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Stage 1: offsets. Stage 2: magnitudes. Stage 3: squares.
  // Stage 4: sum of squares and the radius compare.
  always_ff @(posedge clk) begin
    row1_r <= in_row_index;
    col1_r <= in_col_index;
    dx_r   <= DIFF_W'(in_query_x) - DIFF_W'(in_grid_x);
    dy_r   <= DIFF_W'(in_query_y) - DIFF_W'(in_grid_y);

    row2_r <= row1_r;
    col2_r <= col1_r;
    nx2_r  <= dx_r[DIFF_W-1];
    ny2_r  <= dy_r[DIFF_W-1];
    ax2_r  <= dx_r[DIFF_W-1] ? MAG_W'(-dx_r) : MAG_W'(dx_r);
    ay2_r  <= dy_r[DIFF_W-1] ? MAG_W'(-dy_r) : MAG_W'(dy_r);

    row3_r <= row2_r;
    col3_r <= col2_r;
    nx3_r  <= nx2_r;
    ny3_r  <= ny2_r;
    ax3_r  <= ax2_r;
    ay3_r  <= ay2_r;
    sqx_r  <= SQ_W'(ax2_r) * SQ_W'(ax2_r);
    sqy_r  <= SQ_W'(ay2_r) * SQ_W'(ay2_r);

    row4_r <= row3_r;
    col4_r <= col3_r;
    nx4_r  <= nx3_r;
    ny4_r  <= ny3_r;
    ax4_r  <= ax3_r;
    ay4_r  <= ay3_r;
    sum_r  <= sqx_r + sqy_r;
    hit4_r <= ((sqx_r + sqy_r) != '0) && ((sqx_r + sqy_r) < r2_r);
  end

  assign side4 = '{hit: hit4_r, row: row4_r, col: col4_r, mag_x: ax4_r,
                   mag_y: ay4_r, neg_x: nx4_r, neg_y: ny4_r};

  rnd_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v4_r),
    .in_rad    (sum_r),
    .in_side   (side4),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  rnd_divider u_div_x (
    .clk     (clk),
    .in_mag  (sq_side.mag_x),
    .in_dvs  (sq_root),
    .out_quo (quo_x)
  );

  rnd_divider u_div_y (
    .clk     (clk),
    .in_mag  (sq_side.mag_y),
    .in_dvs  (sq_root),
    .out_quo (quo_y)
  );

  // The indices, distance and signs ride along with the dividers.
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_tail
    if (s == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          tv_r[s] <= 1'b0;
        end else begin
          tv_r[s] <= sq_valid;
        end
      end
      always_ff @(posedge clk) begin
        tail_r[s] <= '{hit: sq_side.hit, row: sq_side.row, col: sq_side.col,
                       root: sq_root, neg_x: sq_side.neg_x,
                       neg_y: sq_side.neg_y};
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          tv_r[s] <= 1'b0;
        end else begin
          tv_r[s] <= tv_r[s-1];
        end
      end
      always_ff @(posedge clk) begin
        tail_r[s] <= tail_r[s-1];
      end
    end
  end

  assign tl     = tail_r[DIV_STAGES-1];
  assign qx_ext = DIR_W'(quo_x);
  assign qy_ext = DIR_W'(quo_y);

  // Output register; a miss clears every field.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= tv_r[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (tl.hit) begin
      out_hit        <= 1'b1;
      out_row_number <= ROWNUM_W'(tl.row) + ROWNUM_W'(1);
      out_col_number <= COLNUM_W'(tl.col) + COLNUM_W'(1);
      out_distance   <= tl.root;
      out_dir_x      <= tl.neg_x ? -qx_ext : qx_ext;
      out_dir_y      <= tl.neg_y ? -qy_ext : qy_ext;
    end else begin
      out_hit        <= 1'b0;
      out_row_number <= '0;
      out_col_number <= '0;
      out_distance   <= '0;
      out_dir_x      <= '0;
      out_dir_y      <= '0;
    end
  end

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

// Checks the radius neighbor distance unit by streaming query/grid pairs,
// computing the expected hit, indices, distance and direction for every pair
// in a local integer model, and comparing each strobed result in order.
module tb_top;
  import rnd_pkg::*;

  // One pair as it is driven into the unit.
  typedef struct {
    logic [ROW_W-1:0]          row;
    logic [COL_W-1:0]          col;
    logic signed [COORD_W-1:0] qx;
    logic signed [COORD_W-1:0] qy;
    logic signed [COORD_W-1:0] gx;
    logic signed [COORD_W-1:0] gy;
  } pair_t;

  // One neighbor report.
  typedef struct {
    logic                      hit;
    logic [ROWNUM_W-1:0]       row_number;
    logic [COLNUM_W-1:0]       col_number;
    logic [ROOT_W-1:0]         distance;
    logic signed [DIR_W-1:0]   dir_x;
    logic signed [DIR_W-1:0]   dir_y;
  } report_t;

  // The settle margin is taken above the unit's own latency.
  localparam int SETTLE_CYCLES = 40;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [ROW_W-1:0] in_row_index;
  logic [COL_W-1:0] in_col_index;
  logic signed [COORD_W-1:0] in_query_x, in_query_y, in_grid_x, in_grid_y;
  logic out_valid, out_hit;
  logic [ROWNUM_W-1:0] out_row_number;
  logic [COLNUM_W-1:0] out_col_number;
  logic [ROOT_W-1:0] out_distance;
  logic signed [DIR_W-1:0] out_dir_x, out_dir_y;
  logic cfg_valid, cfg_ready;
  logic [RAD_W-1:0] cfg_radius;

  radius_neighbor_distance_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_row_index(in_row_index), .in_col_index(in_col_index),
    .in_query_x(in_query_x), .in_query_y(in_query_y),
    .in_grid_x(in_grid_x), .in_grid_y(in_grid_y),
    .out_valid(out_valid), .out_hit(out_hit),
    .out_row_number(out_row_number), .out_col_number(out_col_number),
    .out_distance(out_distance), .out_dir_x(out_dir_x), .out_dir_y(out_dir_y),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_radius(cfg_radius)
  );

  // The radius as the model sees it, updated on each accepted write.
  logic [RAD_W-1:0] model_radius;

  pair_t   pending_pairs[$];
  report_t expected_reports[$];
  int      error_count;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Safety net: well beyond 700 items with long gaps plus several phases.
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

  // Integer floor square root, bit by bit.
  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned rem, root, b;
    rem  = v;
    root = 0;
    b    = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem  = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  // Offset scaled to Q1.14 and divided by the distance, truncated toward zero.
  function automatic logic signed [DIR_W-1:0] unit_component(input longint off,
                                                             input longint unsigned dist_val);
    longint unsigned mag, q;
    mag = (off < 0) ? -off : off;
    q   = (mag << DIR_FRAC) / dist_val;
    return (off < 0) ? DIR_W'(-q) : DIR_W'(q);
  endfunction

  // Expected report for one pair under the current radius.
  function automatic report_t neighbor_report(input pair_t p);
    report_t r;
    longint dx, dy;
    longint unsigned sq, r2, dist_val;
    dx = longint'(p.qx) - longint'(p.gx);
    dy = longint'(p.qy) - longint'(p.gy);
    sq = dx * dx + dy * dy;
    r2 = longint'(model_radius) * longint'(model_radius);
    r  = '{default: '0};
    if (sq != 0 && sq < r2) begin
      dist_val     = floor_sqrt(sq);
      r.hit        = 1'b1;
      r.row_number = ROWNUM_W'(p.row) + 1'b1;
      r.col_number = COLNUM_W'(p.col) + 1'b1;
      r.distance   = ROOT_W'(dist_val);
      r.dir_x      = unit_component(dx, dist_val);
      r.dir_y      = unit_component(dy, dist_val);
    end
    return r;
  endfunction

  // Short gaps usually, a long one now and then.
  function automatic int gap_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Driver: presents queued pairs, holding start across back-to-back items.
  int drive_gap;
  bit no_idle_phase;
  always @(posedge clk) begin
    if (!rst_n) begin
      start     <= 1'b0;
      drive_gap <= 0;
    end else if (start && busy) begin
      // Held until the unit takes it.
    end else if (drive_gap > 0) begin
      start     <= 1'b0;
      drive_gap <= drive_gap - 1;
    end else if (pending_pairs.size() > 0) begin
      pair_t p;
      p = pending_pairs.pop_front();
      start        <= 1'b1;
      in_row_index <= p.row;
      in_col_index <= p.col;
      in_query_x   <= p.qx;
      in_query_y   <= p.qy;
      in_grid_x    <= p.gx;
      in_grid_y    <= p.gy;
      expected_reports.push_back(neighbor_report(p));
      drive_gap    <= no_idle_phase ? 0 : gap_length();
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: every strobed result must match the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_reports.size() == 0) begin
        $error("result with none expected");
        error_count++;
      end else begin
        report_t e;
        e = expected_reports.pop_front();
        if (out_hit !== e.hit) begin
          $error("hit: expected %0d got %0d", e.hit, out_hit);
          error_count++;
        end
        if (out_row_number !== e.row_number) begin
          $error("row_number: expected %0d got %0d", e.row_number, out_row_number);
          error_count++;
        end
        if (out_col_number !== e.col_number) begin
          $error("col_number: expected %0d got %0d", e.col_number, out_col_number);
          error_count++;
        end
        if (out_distance !== e.distance) begin
          $error("distance: expected %0d got %0d", e.distance, out_distance);
          error_count++;
        end
        if (out_dir_x !== e.dir_x) begin
          $error("dir_x: expected %0d got %0d", e.dir_x, out_dir_x);
          error_count++;
        end
        if (out_dir_y !== e.dir_y) begin
          $error("dir_y: expected %0d got %0d", e.dir_y, out_dir_y);
          error_count++;
        end
      end
    end
  end

  function automatic pair_t make_pair(input int r, input int c, input int qx,
                                      input int qy, input int gx, input int gy);
    pair_t p;
    p.row = ROW_W'(r);
    p.col = COL_W'(c);
    p.qx  = COORD_W'(qx);
    p.qy  = COORD_W'(qy);
    p.gx  = COORD_W'(gx);
    p.gy  = COORD_W'(gy);
    return p;
  endfunction

  // Random pair: mostly offsets scaled to the radius so hits and near misses
  // both occur, the rest full-range coordinates.
  function automatic pair_t random_pair(input int span);
    pair_t p;
    p.row = ROW_W'($urandom);
    p.col = COL_W'($urandom);
    p.qx  = COORD_W'($urandom);
    p.qy  = COORD_W'($urandom);
    if ($urandom_range(0, 3) != 0) begin
      p.gx = p.qx - COORD_W'($urandom_range(0, 2 * span) - span);
      p.gy = p.qy - COORD_W'($urandom_range(0, 2 * span) - span);
    end else begin
      p.gx = COORD_W'($urandom);
      p.gy = COORD_W'($urandom);
    end
    return p;
  endfunction

  // Writes the radius while the unit is idle, then waits for the handshake.
  task automatic write_radius(input logic [RAD_W-1:0] value);
    @(posedge clk);
    cfg_valid  <= 1'b1;
    cfg_radius <= value;
    do @(posedge clk); while (!cfg_ready);
    model_radius = value;
    cfg_valid <= 1'b0;
  endtask

  // Waits until the results of the current phase have all come back.
  task automatic drain();
    while (pending_pairs.size() > 0 || expected_reports.size() > 0 || start)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Radius per random phase; extremes included, a span of offsets to match.
  int radius_plan[6] = '{92682, 1, 131071, 300, 46341, 0};

  initial begin
    error_count   = 0;
    no_idle_phase = 0;
    model_radius  = '0;
    rst_n         = 1'b0;
    start         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_radius    = '0;
    in_row_index  = '0;
    in_col_index  = '0;
    in_query_x    = '0;
    in_query_y    = '0;
    in_grid_x     = '0;
    in_grid_y     = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero radius right after reset: nothing can hit.
    pending_pairs.push_back(make_pair(5, 6, 10, 10, 0, 0));
    drain();

    write_radius(RAD_W'(92682));
    // Coincident points never hit.
    pending_pairs.push_back(make_pair(0, 0, 123, -45, 123, -45));
    // Axis offsets of one unit give a full-scale direction.
    pending_pairs.push_back(make_pair(0, 0, 1, 0, 0, 0));
    pending_pairs.push_back(make_pair(1, 1, 0, -1, 0, 0));
    pending_pairs.push_back(make_pair(2, 2, -1, 0, 0, 0));
    pending_pairs.push_back(make_pair(3, 3, 0, 0, 0, 1));
    // Largest indices carry their one-based numbers into the wider fields.
    pending_pairs.push_back(make_pair(1048575, 65535, 3, 4, 0, 0));
    // Extreme coordinates: opposite corners, just inside the radius.
    pending_pairs.push_back(make_pair(7, 8, 32767, 32767, -32768, -32768));
    pending_pairs.push_back(make_pair(9, 10, -32768, 32767, 32767, -32768));
    // One axis at full span, within the radius.
    pending_pairs.push_back(make_pair(11, 12, 32767, 0, -32768, 0));
    pending_pairs.push_back(make_pair(13, 14, 32767, 32767, -32768, 0));
    pending_pairs.push_back(make_pair(15, 16, 0, -32768, 0, 32767));
    // Diagonal offsets exercise truncation of the direction.
    pending_pairs.push_back(make_pair(17, 18, 7, -7, 0, 0));
    pending_pairs.push_back(make_pair(19, 20, -1000, 333, 0, 0));
    drain();

    // Offset exactly at the radius misses; one below hits.
    write_radius(RAD_W'(5));
    pending_pairs.push_back(make_pair(21, 22, 3, 4, 0, 0));
    pending_pairs.push_back(make_pair(23, 24, 3, 3, 0, 0));
    pending_pairs.push_back(make_pair(25, 26, 0, 0, 0, 4));
    drain();

    // Random phases, about 700 items across all radius settings.
    foreach (radius_plan[i]) begin
      int span;
      write_radius(RAD_W'(radius_plan[i]));
      span = (radius_plan[i] < 2) ? 3 : (radius_plan[i] > 40000 ? 40000 : radius_plan[i]);
      no_idle_phase = (i == 2);
      repeat (115) pending_pairs.push_back(random_pair(span));
      drain();
    end
    no_idle_phase = 0;

    if (error_count == 0 && expected_reports.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: radius_neighbor_distance_unit.f
rtl/core/rnd_pkg.sv
rtl/core/rnd_isqrt.sv
rtl/core/rnd_divider.sv
rtl/core/radius_neighbor_distance_unit.sv
tb/tb_top.sv
